// ===== design/crm_pkg.sv =====
// Shared types and constants for the cartesian-to-radar measurement pipeline.
// Used by crm_divider and cartesian_to_radar_measurement; no dependencies.
package crm_pkg;

    // Stage counts
    localparam int CORDIC_STAGES = 24;   // 12..32
    localparam int SQRT_STEPS    = 32;
    localparam int DIV_STEPS     = 32;

    // Angle constants, LSB 2^-28 rad
    localparam logic signed [32:0] ANG_PI      = 33'sd843314857;
    localparam logic signed [32:0] ANG_HALF_PI = 33'sd421657428;
    localparam logic signed [32:0] ANG_TWO_PI  = 33'sd1686629713;

    // CORDIC gain and unity in Q4.30
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

    // Reset value of the range floor register, Q1.16
    localparam logic [16:0] MIN_RANGE_RST = 17'd7;

    // Saturation limits of range rate
    localparam logic signed [31:0] RATE_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] RATE_MIN = 32'sh8000_0000;

    // arctan(2^-i) in 2^-28 rad
    function automatic logic signed [31:0] atan_q28(input int idx);
        logic signed [31:0] v;
        case (idx)
            0:  v = 32'sd210828714;
            1:  v = 32'sd124459457;
            2:  v = 32'sd65760959;
            3:  v = 32'sd33381290;
            4:  v = 32'sd16755422;
            5:  v = 32'sd8385879;
            6:  v = 32'sd4193963;
            7:  v = 32'sd2097109;
            8:  v = 32'sd1048571;
            9:  v = 32'sd524287;
            10: v = 32'sd262144;
            11: v = 32'sd131072;
            12: v = 32'sd65536;
            13: v = 32'sd32768;
            14: v = 32'sd16384;
            15: v = 32'sd8192;
            16: v = 32'sd4096;
            17: v = 32'sd2048;
            18: v = 32'sd1024;
            19: v = 32'sd512;
            20: v = 32'sd256;
            21: v = 32'sd128;
            22: v = 32'sd64;
            23: v = 32'sd32;
            24: v = 32'sd16;
            25: v = 32'sd8;
            26: v = 32'sd4;
            27: v = 32'sd2;
            28: v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Fields that ride alongside the division
    typedef struct packed {
        logic [31:0]        rng;
        logic signed [30:0] bearing;
    } t_side;

    // Divider request and result
    typedef struct packed {
        logic        vld;
        logic [63:0] num;
        logic [31:0] den;
        logic        neg;
        t_side       side;
    } t_div_req;

    typedef struct packed {
        logic        vld;
        logic [31:0] quot;
        logic        sat;
        logic        neg;
        t_side       side;
    } t_div_res;

endpackage

// ===== design/cartesian_to_radar_measurement.sv =====
// Top level: range, bearing and range rate from a Cartesian track state.
// Depends on crm_pkg and crm_divider.
//
// Takes one transaction per clock unless stalled and returns one result per
// transaction, in order. Each passes through the 32-step square root pipeline
// (which also hosts the CORDIC stages) and the 32-step divider pipeline. The
// whole pipeline advances together: it holds whenever a result waits on the
// output and the master side is not ready. Range is floor(sqrt(x^2+y^2))
// raised to min_range (0 acts as 1), bearing is a vectoring CORDIC atan2 (0
// at the origin), and range rate is the radial velocity divided by range,
// saturated to the signed 32-bit limits. The user must write min_range via
// i_cfg_we/i_cfg_wdata while the block is idle; the block does not enforce it.
module cartesian_to_radar_measurement (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration
    input  logic          i_cfg_we,
    input  logic [16:0]   i_cfg_wdata,      // min_range, Q1.16
    // input stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [127:0]  i_s_axis_tdata,   // pos_x, pos_y, speed, heading
    // output stream
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [95:0]   o_m_axis_tdata    // range, bearing, range_rate, pad
);
    import crm_pkg::*;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] v;
        logic signed [31:0] h;
        logic [31:0]        flr;
    } t_s0;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] v;
        logic [63:0]        px2;
        logic [63:0]        py2;
        logic signed [31:0] ang;
        logic               rneg;
        logic signed [49:0] vx;
        logic signed [49:0] vy;
        logic signed [31:0] vz;
        logic               zero;
        logic [31:0]        flr;
    } t_s1;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] v;
        logic [31:0]        flr;
        logic [63:0]        sq_n;
        logic [63:0]        sq_r;
        logic signed [33:0] rx;
        logic signed [33:0] ry;
        logic signed [31:0] rz;
        logic               rneg;
        logic signed [49:0] vx;
        logic signed [49:0] vy;
        logic signed [31:0] vz;
        logic               zero;
    } t_core;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] v;
        logic signed [31:0] c;
        logic signed [31:0] s;
        t_side              side;
    } t_p1;

    typedef struct packed {
        logic               vld;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [32:0] vc;
        logic signed [32:0] vs;
        t_side              side;
    } t_p2;

    typedef struct packed {
        logic               vld;
        logic signed [64:0] p1;
        logic signed [64:0] p2;
        t_side              side;
    } t_p3;

    typedef struct packed {
        logic               vld;
        logic signed [65:0] sum;
        t_side              side;
    } t_p4;

    typedef struct packed {
        logic               vld;
        logic [31:0]        rng;
        logic signed [30:0] bearing;
        logic signed [31:0] rate;
    } t_out;

    logic        w_adv;
    logic [16:0] r_min_range;
    t_s0         r_s0;
    t_s1         r_s1;
    t_core       r_core [0:SQRT_STEPS];
    t_p1         r_p1;
    t_p2         r_p2;
    t_p3         r_p3;
    t_p4         r_p4;
    t_out        r_out;
    t_div_req    w_req;
    t_div_res    w_res;

    // Whole pipeline moves unless a result is stuck on the output
    assign w_adv           = !r_out.vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // Range floor register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range <= MIN_RANGE_RST;
        end else if (i_cfg_we) begin
            r_min_range <= i_cfg_wdata;
        end
    end

    // Stage 0: capture transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else if (w_adv) begin
            r_s0.vld <= i_s_axis_tvalid;
            r_s0.px  <= i_s_axis_tdata[31:0];
            r_s0.py  <= i_s_axis_tdata[63:32];
            r_s0.v   <= i_s_axis_tdata[95:64];
            r_s0.h   <= i_s_axis_tdata[127:96];
            r_s0.flr <= (r_min_range == 17'd0) ? 32'd1 : {15'd0, r_min_range};
        end
    end

    // Stage 1: squares, heading reduction and fold, atan2 pre-rotation
    t_s1 n_s1;
    always_comb begin
        logic signed [32:0] a;
        logic signed [49:0] xs;
        logic signed [49:0] ys;
        n_s1      = r_s1;
        n_s1.vld  = r_s0.vld;
        n_s1.px   = r_s0.px;
        n_s1.py   = r_s0.py;
        n_s1.v    = r_s0.v;
        n_s1.flr  = r_s0.flr;
        n_s1.px2  = 64'(r_s0.px) * 64'(r_s0.px);
        n_s1.py2  = 64'(r_s0.py) * 64'(r_s0.py);
        // bring into [-pi, pi]
        a = 33'($signed(r_s0.h));
        if (a > ANG_PI) begin
            a = a - ANG_TWO_PI;
        end else if (a < -ANG_PI) begin
            a = a + ANG_TWO_PI;
        end
        // fold into [-pi/2, pi/2]
        n_s1.rneg = 1'b0;
        if (a > ANG_HALF_PI) begin
            a = a - ANG_PI;
            n_s1.rneg = 1'b1;
        end else if (a < -ANG_HALF_PI) begin
            a = a + ANG_PI;
            n_s1.rneg = 1'b1;
        end
        n_s1.ang  = a[31:0];
        // vectoring start, left half-plane rotated by +-pi/2
        xs = {{2{r_s0.px[31]}}, r_s0.px, 16'd0};
        ys = {{2{r_s0.py[31]}}, r_s0.py, 16'd0};
        n_s1.zero = (r_s0.px == 32'sd0) && (r_s0.py == 32'sd0);
        if (xs < 0) begin
            if (ys >= 0) begin
                n_s1.vx = ys;
                n_s1.vy = -xs;
                n_s1.vz = ANG_HALF_PI[31:0];
            end else begin
                n_s1.vx = -ys;
                n_s1.vy = xs;
                n_s1.vz = -ANG_HALF_PI[31:0];
            end
        end else begin
            n_s1.vx = xs;
            n_s1.vy = ys;
            n_s1.vz = 32'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else if (w_adv) begin
            r_s1 <= n_s1;
        end
    end

    // Core entry: sum of squares, CORDIC seeds
    t_core n_core0;
    always_comb begin
        n_core0      = r_core[0];
        n_core0.vld  = r_s1.vld;
        n_core0.px   = r_s1.px;
        n_core0.py   = r_s1.py;
        n_core0.v    = r_s1.v;
        n_core0.flr  = r_s1.flr;
        n_core0.sq_n = r_s1.px2 + r_s1.py2;
        n_core0.sq_r = '0;
        n_core0.rx   = GAIN_Q30;
        n_core0.ry   = 34'sd0;
        n_core0.rz   = r_s1.ang;
        n_core0.rneg = r_s1.rneg;
        n_core0.vx   = r_s1.vx;
        n_core0.vy   = r_s1.vy;
        n_core0.vz   = r_s1.vz;
        n_core0.zero = r_s1.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core[0].vld <= 1'b0;
        end else if (w_adv) begin
            r_core[0] <= n_core0;
        end
    end

    // Core stages: one square-root digit plus, in the first CORDIC_STAGES stages, one step of each CORDIC
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_core
        localparam logic [63:0] SqBit = 64'd1 << (62 - 2 * k);
        t_core n_c;
        always_comb begin
            logic [63:0]        trial;
            logic signed [33:0] rdx;
            logic signed [33:0] rdy;
            logic signed [49:0] vdx;
            logic signed [49:0] vdy;
            n_c   = r_core[k];
            trial = r_core[k].sq_r + SqBit;
            if (r_core[k].sq_n >= trial) begin
                n_c.sq_n = r_core[k].sq_n - trial;
                n_c.sq_r = (r_core[k].sq_r >> 1) + SqBit;
            end else begin
                n_c.sq_r = r_core[k].sq_r >> 1;
            end
            rdx = r_core[k].ry >>> k;
            rdy = r_core[k].rx >>> k;
            vdx = r_core[k].vy >>> k;
            vdy = r_core[k].vx >>> k;
            if (k < CORDIC_STAGES) begin
                // rotation toward the heading
                if (r_core[k].rz >= 0) begin
                    n_c.rx = r_core[k].rx - rdx;
                    n_c.ry = r_core[k].ry + rdy;
                    n_c.rz = r_core[k].rz - atan_q28(k);
                end else begin
                    n_c.rx = r_core[k].rx + rdx;
                    n_c.ry = r_core[k].ry - rdy;
                    n_c.rz = r_core[k].rz + atan_q28(k);
                end
                // vectoring toward the x axis
                if (r_core[k].vy > 0) begin
                    n_c.vx = r_core[k].vx + vdx;
                    n_c.vy = r_core[k].vy - vdy;
                    n_c.vz = r_core[k].vz + atan_q28(k);
                end else begin
                    n_c.vx = r_core[k].vx - vdx;
                    n_c.vy = r_core[k].vy + vdy;
                    n_c.vz = r_core[k].vz - atan_q28(k);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_core[k+1].vld <= 1'b0;
            end else if (w_adv) begin
                r_core[k+1] <= n_c;
            end
        end
    end

    // P1: unfold and clamp sin/cos, clamp bearing, raise range
    t_p1 n_p1;
    always_comb begin
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [32:0] bz;
        logic [31:0]        root;
        cx   = r_core[SQRT_STEPS].rneg ? -r_core[SQRT_STEPS].rx : r_core[SQRT_STEPS].rx;
        cy   = r_core[SQRT_STEPS].rneg ? -r_core[SQRT_STEPS].ry : r_core[SQRT_STEPS].ry;
        bz   = 33'(r_core[SQRT_STEPS].vz);
        root = r_core[SQRT_STEPS].sq_r[31:0];
        n_p1.vld = r_core[SQRT_STEPS].vld;
        n_p1.px  = r_core[SQRT_STEPS].px;
        n_p1.py  = r_core[SQRT_STEPS].py;
        n_p1.v   = r_core[SQRT_STEPS].v;
        if (cx > ONE_Q30) begin
            n_p1.c = ONE_Q30[31:0];
        end else if (cx < -ONE_Q30) begin
            n_p1.c = -ONE_Q30[31:0];
        end else begin
            n_p1.c = cx[31:0];
        end
        if (cy > ONE_Q30) begin
            n_p1.s = ONE_Q30[31:0];
        end else if (cy < -ONE_Q30) begin
            n_p1.s = -ONE_Q30[31:0];
        end else begin
            n_p1.s = cy[31:0];
        end
        if (r_core[SQRT_STEPS].zero) begin
            n_p1.side.bearing = 31'sd0;
        end else if (bz > ANG_PI) begin
            n_p1.side.bearing = ANG_PI[30:0];
        end else if (bz < -ANG_PI) begin
            n_p1.side.bearing = -ANG_PI[30:0];
        end else begin
            n_p1.side.bearing = bz[30:0];
        end
        n_p1.side.rng = (root < r_core[SQRT_STEPS].flr) ? r_core[SQRT_STEPS].flr : root;
    end

    // P2: velocity components, floor(v*cos / 2^30)
    t_p2 n_p2;
    always_comb begin
        logic signed [63:0] mc;
        logic signed [63:0] ms;
        mc = $signed(r_p1.v) * $signed(r_p1.c);
        ms = $signed(r_p1.v) * $signed(r_p1.s);
        n_p2.vld  = r_p1.vld;
        n_p2.px   = r_p1.px;
        n_p2.py   = r_p1.py;
        n_p2.vc   = mc[62:30];
        n_p2.vs   = ms[62:30];
        n_p2.side = r_p1.side;
    end

    // P3: position times velocity, Q32.32
    t_p3 n_p3;
    always_comb begin
        n_p3.vld  = r_p2.vld;
        n_p3.p1   = 65'(r_p2.px) * 65'(r_p2.vc);
        n_p3.p2   = 65'(r_p2.py) * 65'(r_p2.vs);
        n_p3.side = r_p2.side;
    end

    // P4: radial numerator
    t_p4 n_p4;
    always_comb begin
        n_p4.vld  = r_p3.vld;
        n_p4.sum  = 66'($signed(r_p3.p1)) + 66'($signed(r_p3.p2));
        n_p4.side = r_p3.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.vld <= 1'b0;
            r_p2.vld <= 1'b0;
            r_p3.vld <= 1'b0;
            r_p4.vld <= 1'b0;
        end else if (w_adv) begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= n_p3;
            r_p4 <= n_p4;
        end
    end

    // Sign and magnitude into the divider
    always_comb begin
        logic signed [65:0] mag;
        mag        = r_p4.sum[65] ? -r_p4.sum : r_p4.sum;
        w_req.vld  = r_p4.vld;
        w_req.num  = mag[63:0];
        w_req.den  = r_p4.side.rng;
        w_req.neg  = r_p4.sum[65];
        w_req.side = r_p4.side;
    end

    crm_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_req   (w_req),
        .o_res   (w_res)
    );

    // Output register with rate saturation
    t_out n_out;
    always_comb begin
        logic signed [32:0] negq;
        negq          = -$signed({1'b0, w_res.quot});
        n_out.vld     = w_res.vld;
        n_out.rng     = w_res.side.rng;
        n_out.bearing = w_res.side.bearing;
        if (w_res.sat) begin
            n_out.rate = w_res.neg ? RATE_MIN : RATE_MAX;
        end else if (w_res.neg) begin
            n_out.rate = (w_res.quot > 32'h8000_0000) ? RATE_MIN : negq[31:0];
        end else begin
            n_out.rate = (w_res.quot > 32'h7fff_ffff) ? RATE_MAX : w_res.quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out.vld;
    assign o_m_axis_tdata  = {1'b0, r_out.rate, r_out.bearing, r_out.rng};

`ifndef SYNTHESIS
    // Reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // An empty output never blocks the input
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    // Range is at least one LSB because of the floor
    a_range_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out.rng != 32'd0))
        else $error("range of zero delivered");

    // Bearing stays within +-pi
    a_bearing_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out.bearing <= ANG_PI)
                         && (r_out.bearing >= -ANG_PI))
        else $error("bearing outside +-pi");

    // Divider overflow always lands on a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_res.vld && w_res.sat) |=>
            (r_out.rate == RATE_MAX) || (r_out.rate == RATE_MIN))
        else $error("overflowed quotient not saturated");
`endif

endmodule

// ===== design/crm_divider.sv =====
// Pipelined restoring divider: 64-bit magnitude over a 32-bit range, one
// quotient bit per stage, with overflow detect. Depends on crm_pkg.
module crm_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  crm_pkg::t_div_req i_req,
    output crm_pkg::t_div_res o_res
);
    import crm_pkg::*;

    typedef struct packed {
        logic        vld;
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] den;
        logic [31:0] quot;
        logic        sat;
        logic        neg;
        t_side       side;
    } t_dstage;

    t_dstage r_st [0:DIV_STEPS];

    // Entry register: upper half starts the remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[0].vld <= 1'b0;
        end else if (i_en) begin
            r_st[0].vld  <= i_req.vld;
            r_st[0].rem  <= i_req.num[63:32];
            r_st[0].low  <= i_req.num[31:0];
            r_st[0].den  <= i_req.den;
            r_st[0].quot <= '0;
            r_st[0].sat  <= 1'b0;
            r_st[0].neg  <= i_req.neg;
            r_st[0].side <= i_req.side;
        end
    end

    // One quotient bit per stage
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        t_dstage n_st;
        always_comb begin
            logic [32:0] rem2;
            logic [32:0] diff;
            n_st = r_st[k];
            rem2 = {r_st[k].rem, r_st[k].low[31]};
            diff = rem2 - {1'b0, r_st[k].den};
            n_st.low = {r_st[k].low[30:0], 1'b0};
            if (rem2 >= {1'b0, r_st[k].den}) begin
                n_st.rem  = diff[31:0];
                n_st.quot = {r_st[k].quot[30:0], 1'b1};
            end else begin
                n_st.rem  = rem2[31:0];
                n_st.quot = {r_st[k].quot[30:0], 1'b0};
            end
            // quotient of 2^32 or more
            if (k == 0) begin
                n_st.sat = (r_st[k].rem >= r_st[k].den);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k+1].vld <= 1'b0;
            end else if (i_en) begin
                r_st[k+1] <= n_st;
            end
        end
    end

    assign o_res.vld  = r_st[DIV_STEPS].vld;
    assign o_res.quot = r_st[DIV_STEPS].quot;
    assign o_res.sat  = r_st[DIV_STEPS].sat;
    assign o_res.neg  = r_st[DIV_STEPS].neg;
    assign o_res.side = r_st[DIV_STEPS].side;

endmodule

// ===== tb/cartesian_to_radar_measurement_tb.sv =====
// Testbench for cartesian_to_radar_measurement: directed and random track states,
// predicted results checked in order through a small scoreboard class.
// Depends on crm_pkg and the design sources.
module cartesian_to_radar_measurement_tb;
    import crm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_MAX  = 5000;
    localparam int DRAIN_WAIT = 100;
    localparam longint PI2    = 64'sd1686629713;
    localparam longint PI1    = 64'sd843314857;
    localparam longint PIH    = 64'sd421657428;

    typedef struct {
        logic [31:0]        rng;
        logic signed [30:0] bearing;
        logic signed [31:0] rate;
    } t_meas;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [16:0]  i_cfg_wdata = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [95:0]  o_m_axis_tdata;

    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  sink_on = 1'b0;

    // Arctan table, LSB 2^-28 rad
    function automatic longint atan_step(int i);
        longint t[29] = '{210828714, 124459457, 65760959, 33381290, 16755422,
            8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
            32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
            4, 2, 1};
        return (i < 29) ? t[i] : 0;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    class meas_scoreboard;
        t_meas      pending[$];
        logic [16:0] floor_reg = MIN_RANGE_RST;

        function longint unsigned root(longint unsigned n);
            longint unsigned r = 0, b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function t_meas predict(logic [127:0] d);
            t_meas m;
            longint px, py, v, h, x, y, z, dx, dy, t, vc, vs, p1, p2;
            longint unsigned r, fl, m1, m2, mag, q;
            bit flip, neg;
            px = longint'($signed(d[31:0]));
            py = longint'($signed(d[63:32]));
            v  = longint'($signed(d[95:64]));
            h  = longint'($signed(d[127:96]));
            r = root(longint'(px * px) + longint'(py * py));
            fl = (floor_reg == 0) ? 1 : floor_reg;
            if (r < fl) r = fl;
            // vectoring CORDIC for bearing
            z = 0;
            if (px != 0 || py != 0) begin
                x = px <<< 16;
                y = py <<< 16;
                if (x < 0) begin
                    t = x;
                    if (y >= 0) begin
                        x = y; y = -t; z = PIH;
                    end else begin
                        x = -y; y = t; z = -PIH;
                    end
                end
                for (int i = 0; i < CORDIC_STAGES; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y > 0) begin
                        x += dx; y -= dy; z += atan_step(i);
                    end else begin
                        x -= dx; y += dy; z -= atan_step(i);
                    end
                end
                z = clip(z, -PI1, PI1);
            end
            // rotation CORDIC for cos/sin of heading
            for (int k = 0; k < 2; k++) begin
                if (h > PI1) h -= PI2;
                if (h < -PI1) h += PI2;
            end
            flip = 1'b0;
            if (h > PIH) begin
                h -= PI1; flip = 1'b1;
            end else if (h < -PIH) begin
                h += PI1; flip = 1'b1;
            end
            x = 652032874;
            y = 0;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (h >= 0) begin
                    x -= dx; y += dy; h -= atan_step(i);
                end else begin
                    x += dx; y -= dy; h += atan_step(i);
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            x = clip(x, -(64'sd1 << 30), 64'sd1 << 30);
            y = clip(y, -(64'sd1 << 30), 64'sd1 << 30);
            vc = (v * x) >>> 30;
            vs = (v * y) >>> 30;
            p1 = px * vc;
            p2 = py * vs;
            m1 = p1 < 0 ? -p1 : p1;
            m2 = p2 < 0 ? -p2 : p2;
            if ((p1 < 0) == (p2 < 0)) begin
                mag = m1 + m2; neg = p1 < 0;
            end else if (m1 >= m2) begin
                mag = m1 - m2; neg = p1 < 0;
            end else begin
                mag = m2 - m1; neg = p2 < 0;
            end
            q = mag / r;
            if (neg) m.rate = (q > 64'd2147483648) ? RATE_MIN : 32'(-longint'(q));
            else m.rate = (q > 64'd2147483647) ? RATE_MAX : 32'(q);
            m.rng = r[31:0];
            m.bearing = z[30:0];
            return m;
        endfunction

        function void note_input(logic [127:0] d);
            pending.push_back(predict(d));
        endfunction

        function void check_result(logic [95:0] d);
            t_meas e;
            if (pending.size() == 0) begin
                $error("unexpected result %h", d);
                fail_count++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.rng) begin
                $error("range: expected %0d, got %0d", e.rng, d[31:0]);
                fail_count++;
            end
            if (d[62:32] !== e.bearing) begin
                $error("bearing: expected %0d, got %0d", e.bearing, $signed(d[62:32]));
                fail_count++;
            end
            if (d[94:63] !== e.rate) begin
                $error("range_rate: expected %0d, got %0d", e.rate, $signed(d[94:63]));
                fail_count++;
            end
        endfunction
    endclass

    meas_scoreboard sb = new();

    cartesian_to_radar_measurement dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Monitor both handshakes and the watchdog at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) sb.note_input(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready) sb.check_result(o_m_axis_tdata);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_MAX) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: random backpressure once sink_on is set, mostly short, some long
    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            if (!sink_on) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                g = gap_len();
                if (g == 0) begin
                    i_m_axis_tready <= 1'b1;
                end else begin
                    i_m_axis_tready <= 1'b0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    task automatic send(logic [31:0] x, logic [31:0] y, logic [31:0] v, logic [31:0] h,
                        bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {h, v, y, x};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_floor(logic [16:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.floor_reg = val;
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 65535) - 32768;
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return $urandom_range(0, 7) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int n, bit gaps);
        for (int i = 0; i < n; i++)
            send(rand_field(), rand_field(), rand_field(), rand_field(), gaps);
    endtask

    initial begin
        logic [31:0] mn, mx;
        mn = 32'h8000_0000;
        mx = 32'h7fff_ffff;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: origin, extremes, axes, wrapped headings
        send(0, 0, 0, 0, 0);
        send(0, 0, mx, mx, 0);
        send(mx, mx, mx, 0, 0);
        send(mn, mn, mn, mn, 0);
        send(mx, mn, mn, mx, 0);
        send(mn, mx, mx, mn, 0);
        send(32'h0001_0000, 0, 32'h0001_0000, 0, 0);
        send(0, 32'h0001_0000, 32'h0001_0000, 32'd421657428, 0);
        send(32'hffff_0000, 0, 32'h0001_0000, 32'd843314857, 0);
        send(0, 32'hffff_0000, 32'h0001_0000, -32'sd843314857, 0);
        send(32'hffff_0000, 32'hffff_0000, mx, 32'd1686629713, 0);
        send(1, 0, mx, 0, 0);
        send(1, 1, mn, 0, 0);
        send(32'hffff_ffff, 0, mx, 32'd843314857, 0);
        drain();

        // Zero floor acts as one; then other settings including extremes
        write_floor(17'd0);
        send(0, 0, 5, 0, 0);
        send(1, 0, mx, 0, 0);
        send(32'hffff_ffff, 0, mn, 0, 0);
        send_random(100, 1);
        drain();

        sink_on = 1'b1;
        write_floor(17'h1_0000);
        send(0, 0, 0, 0, 0);
        send(32'h0000_8000, 0, mx, 0, 0);
        send_random(450, 1);
        drain();

        write_floor(17'h1_ffff);
        send_random(400, 1);
        drain();

        write_floor(17'd1);
        send_random(400, 0);
        drain();

        write_floor(MIN_RANGE_RST);
        send_random(400, 1);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
